// ----- rtl/remote_frame_decoder_key_edges_top_macros.svh -----
// Assertion macros shared by the decoder RTL.
`ifndef REMOTE_FRAME_DECODER_KEY_EDGES_TOP_MACROS_SVH
`define REMOTE_FRAME_DECODER_KEY_EDGES_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// The consequent must hold in the same cycle as the antecedent.
`define RFDKE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rfdke: same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define RFDKE_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rfdke: next-cycle check failed");
`else
`define RFDKE_ASSERT_IMP(label, clk, rst, ante, cons)
`define RFDKE_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/rfdke_pkg.sv -----
package rfdke_pkg;

   localparam int unsigned FRAME_BYTES = 18;
   localparam int unsigned POS_W       = 5;
   localparam int unsigned CH_COUNT    = 5;
   localparam int unsigned CH_IDX_W    = 3;
   localparam int unsigned CSR_ADDR_W  = 4;
   localparam int unsigned CSR_DATA_W  = 32;

   localparam logic [11:0] STICK_CENTRE = 12'd1024;
   localparam logic [10:0] CH_MASK      = 11'h7FF;
   localparam logic [3:0]  SW_LOW_MASK  = 4'h3;
   localparam logic [3:0]  SW_HIGH_MASK = 4'hC;

   localparam logic OP_BYTE  = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   localparam logic [1:0] KIND_STICKS = 2'd0;
   localparam logic [1:0] KIND_MOUSE  = 2'd1;
   localparam logic [1:0] KIND_COUNT  = 2'd2;

   localparam logic [1:0] REG_CHANNEL_LIMIT = 2'd0;
   localparam logic [1:0] REG_SHIFT_KEY_BIT = 2'd1;
   localparam logic [1:0] REG_CTRL_KEY_BIT  = 2'd2;

   localparam logic [9:0] CHANNEL_LIMIT_RESET = 10'd660;
   localparam logic [3:0] SHIFT_KEY_RESET     = 4'd4;
   localparam logic [3:0] CTRL_KEY_RESET      = 4'd5;

endpackage

// ----- rtl/rfdke_if.sv -----
interface rfdke_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] frame_byte;
   logic       frame_start;

   modport source (output valid, op, frame_byte, frame_start, input ready);
   modport sink   (input valid, op, frame_byte, frame_start, output ready);
endinterface

interface rfdke_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [15:0] word_a;
   logic [15:0] word_b;
   logic [15:0] word_c;
   logic [15:0] word_d;
   logic [15:0] word_e;
   logic [7:0]  small_f;
   logic [7:0]  small_g;
   logic        last;

   modport source (output valid, kind, word_a, word_b, word_c, word_d, word_e,
                   small_f, small_g, last, input ready);
   modport sink   (input valid, kind, word_a, word_b, word_c, word_d, word_e,
                   small_f, small_g, last, output ready);
endinterface

// ----- rtl/remote_frame_decoder_key_edges_top.sv -----
// Remote-control frame decoder with key-press edge counting.
// req_ch carries one frame byte per transfer (or a clear operation); rsp_ch
// carries the decoded results. Each channel is a valid/ready handshake.
// A frame byte is taken whenever the block is idle, so bytes may follow back to back.
// On the last of the 18 bytes one shared subtract-and-compare unit works
// through the five stick channels, one per cycle. Then the sticks item and
// the mouse/keys item leave one after the other, followed by one count item
// per key. For each key the sequencer first reads its counter row from the
// count memory, then updates it, writes it back and loads the result.
// The block is ready for the next frame once the last count item is loaded.
// A clear transfer returns no result.
// The result register is refilled as soon as the receiver takes its item; a
// stalled receiver holds the sequencer, and req_ch stays not ready meanwhile.
// Reset zeroes the byte position, previous keys and all counts (through a
// valid bit per counter row) and loads the register reset values.
// csr_* is an APB-style register port; writes take effect at once.
`include "remote_frame_decoder_key_edges_top_macros.svh"

module remote_frame_decoder_key_edges_top #(
   parameter int unsigned NUM_KEYS    = 16,
   parameter int unsigned COUNT_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   rfdke_req_if.sink                            req_ch,
   rfdke_rsp_if.source                          rsp_ch,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [rfdke_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [rfdke_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [rfdke_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                 csr_pready
);

   localparam int unsigned KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam int unsigned ROW_W = 3 * COUNT_WIDTH;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHAN,
      ST_EMIT_STICKS,
      ST_EMIT_MOUSE,
      ST_KEY_READ,
      ST_KEY_UPDATE
   } state_type;

   // Configuration registers
   logic [9:0] channel_limit_ff;
   logic [3:0] shift_key_bit_ff;
   logic [3:0] ctrl_key_bit_ff;
   logic       csr_write;

   // Sequencer and data path
   state_type                      state_ff;
   logic [rfdke_pkg::POS_W-1:0]    pos_ff;
   logic [rfdke_pkg::CH_IDX_W-1:0] ch_idx_ff;
   logic [KEY_W-1:0]               key_ff;
   logic [15:0]                    prev_keys_ff;
   logic [NUM_KEYS-1:0]            cnt_valid_ff;
   logic [7:0]                     frame_ff [rfdke_pkg::FRAME_BYTES];
   logic [15:0]                    ch_ff [rfdke_pkg::CH_COUNT];

   logic [ROW_W-1:0] cnt_mem [NUM_KEYS];
   logic [ROW_W-1:0] cnt_rd_ff;
   logic [ROW_W-1:0] cnt_row_in;

   // Result register
   logic        rsp_valid_ff;
   logic [1:0]  rsp_kind_ff;
   logic [15:0] rsp_word_a_ff;
   logic [15:0] rsp_word_b_ff;
   logic [15:0] rsp_word_c_ff;
   logic [15:0] rsp_word_d_ff;
   logic [15:0] rsp_word_e_ff;
   logic [7:0]  rsp_small_f_ff;
   logic [7:0]  rsp_small_g_ff;
   logic        rsp_last_ff;

   logic                        req_accept;
   logic                        out_free;
   logic                        rsp_load;
   logic [rfdke_pkg::POS_W-1:0] wr_pos;
   logic                        frame_done;
   logic                        last_key;
   logic                        cnt_we;

   logic [10:0]        ch_raw;
   logic signed [11:0] ch_diff;
   logic signed [11:0] ch_lim;
   logic [15:0]        ch_val_in;

   logic [15:0] keys;
   logic        ctrl_held;
   logic        shift_held;
   logic        prev_ctrl_held;
   logic        prev_shift_held;
   logic [15:0] keys_ctrl;
   logic [15:0] keys_shift;
   logic [3:0]  key_num;
   logic        key_counted;
   logic [2:0]  cnt_inc;
   logic [COUNT_WIDTH-1:0] cnt_old [3];
   logic [COUNT_WIDTH-1:0] cnt_new_in [3];
   logic [31:0]            cnt_wide [3];

   // Register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_limit_ff <= rfdke_pkg::CHANNEL_LIMIT_RESET;
         shift_key_bit_ff <= rfdke_pkg::SHIFT_KEY_RESET;
         ctrl_key_bit_ff  <= rfdke_pkg::CTRL_KEY_RESET;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            rfdke_pkg::REG_CHANNEL_LIMIT: channel_limit_ff <= csr_pwdata[9:0];
            rfdke_pkg::REG_SHIFT_KEY_BIT: shift_key_bit_ff <= csr_pwdata[3:0];
            rfdke_pkg::REG_CTRL_KEY_BIT:  ctrl_key_bit_ff  <= csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         rfdke_pkg::REG_CHANNEL_LIMIT: csr_prdata = {22'd0, channel_limit_ff};
         rfdke_pkg::REG_SHIFT_KEY_BIT: csr_prdata = {28'd0, shift_key_bit_ff};
         rfdke_pkg::REG_CTRL_KEY_BIT:  csr_prdata = {28'd0, ctrl_key_bit_ff};
         default:                      csr_prdata = '0;
      endcase
   end

   // Handshakes
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_ch.valid && (state_ff == ST_IDLE);
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_load     = out_free && ((state_ff == ST_EMIT_STICKS) ||
                                      (state_ff == ST_EMIT_MOUSE) ||
                                      (state_ff == ST_KEY_UPDATE));

   assign wr_pos     = req_ch.frame_start ? '0 : pos_ff;
   assign frame_done = (wr_pos == rfdke_pkg::POS_W'(rfdke_pkg::FRAME_BYTES - 1));

   // Shared channel unit: raw 11-bit field minus the offset, zeroed when
   // its magnitude exceeds the limit.
   always_comb begin
      case (ch_idx_ff)
         3'd0:    ch_raw = {frame_ff[1][2:0], frame_ff[0]};
         3'd1:    ch_raw = {frame_ff[2][5:0], frame_ff[1][7:3]};
         3'd2:    ch_raw = {frame_ff[4][0], frame_ff[3], frame_ff[2][7:6]};
         3'd3:    ch_raw = {frame_ff[5][3:0], frame_ff[4][7:1]};
         default: ch_raw = {frame_ff[17][2:0], frame_ff[16]};
      endcase
      ch_diff   = signed'({1'b0, ch_raw & rfdke_pkg::CH_MASK} - rfdke_pkg::STICK_CENTRE);
      ch_lim    = signed'({2'b00, channel_limit_ff});
      ch_val_in = ((ch_diff > ch_lim) || (ch_diff < -ch_lim)) ? 16'd0
                                                              : {{4{ch_diff[11]}}, ch_diff};
   end

   // Key masks and the edge tests of the current key
   assign keys            = {frame_ff[15], frame_ff[14]};
   assign ctrl_held       = keys[ctrl_key_bit_ff];
   assign shift_held      = keys[shift_key_bit_ff];
   assign prev_ctrl_held  = prev_keys_ff[ctrl_key_bit_ff];
   assign prev_shift_held = prev_keys_ff[shift_key_bit_ff];
   assign keys_ctrl       = ctrl_held ? keys : 16'd0;
   assign keys_shift      = shift_held ? keys : 16'd0;
   assign key_num         = 4'(key_ff);
   assign key_counted     = (key_num != shift_key_bit_ff) && (key_num != ctrl_key_bit_ff);
   assign last_key        = (key_ff == KEY_W'(NUM_KEYS - 1));
   assign cnt_we          = (state_ff == ST_KEY_UPDATE) && out_free;

   always_comb begin
      cnt_inc[0] = key_counted && keys[key_num] && !prev_keys_ff[key_num]
                   && !ctrl_held && !shift_held;
      cnt_inc[1] = key_counted && ctrl_held && keys[key_num]
                   && !(prev_ctrl_held && prev_keys_ff[key_num]);
      cnt_inc[2] = key_counted && shift_held && keys[key_num]
                   && !(prev_shift_held && prev_keys_ff[key_num]);
      for (int j = 0; j < 3; j++) begin
         cnt_old[j]    = cnt_valid_ff[key_ff] ? cnt_rd_ff[j*COUNT_WIDTH +: COUNT_WIDTH]
                                              : '0;
         cnt_new_in[j] = cnt_old[j] + COUNT_WIDTH'(cnt_inc[j]);
         cnt_wide[j]   = 32'(cnt_new_in[j]);
      end
      cnt_row_in = {cnt_new_in[2], cnt_new_in[1], cnt_new_in[0]};
   end

   // Count memory: one row of three counters per key
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[key_ff] <= cnt_row_in;
      end
      if (state_ff == ST_KEY_READ) begin
         cnt_rd_ff <= cnt_mem[key_ff];
      end
   end

   // Sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         ch_idx_ff    <= '0;
         key_ff       <= '0;
         prev_keys_ff <= '0;
         cnt_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  if (req_ch.op == rfdke_pkg::OP_CLEAR) begin
                     prev_keys_ff <= '0;
                     cnt_valid_ff <= '0;
                  end else begin
                     frame_ff[wr_pos] <= req_ch.frame_byte;
                     if (frame_done) begin
                        pos_ff    <= '0;
                        ch_idx_ff <= '0;
                        state_ff  <= ST_CHAN;
                     end else begin
                        pos_ff <= wr_pos + 1'b1;
                     end
                  end
               end
            end
            ST_CHAN: begin
               ch_ff[ch_idx_ff] <= ch_val_in;
               if (ch_idx_ff == rfdke_pkg::CH_IDX_W'(rfdke_pkg::CH_COUNT - 1)) begin
                  state_ff <= ST_EMIT_STICKS;
               end else begin
                  ch_idx_ff <= ch_idx_ff + 1'b1;
               end
            end
            ST_EMIT_STICKS: begin
               if (out_free) begin
                  rsp_kind_ff    <= rfdke_pkg::KIND_STICKS;
                  rsp_word_a_ff  <= ch_ff[0];
                  rsp_word_b_ff  <= ch_ff[1];
                  rsp_word_c_ff  <= ch_ff[2];
                  rsp_word_d_ff  <= ch_ff[3];
                  rsp_word_e_ff  <= ch_ff[4];
                  rsp_small_f_ff <= {4'd0, frame_ff[5][7:4] & rfdke_pkg::SW_LOW_MASK};
                  rsp_small_g_ff <= {4'd0, (frame_ff[5][7:4] & rfdke_pkg::SW_HIGH_MASK) >> 2};
                  rsp_last_ff    <= 1'b0;
                  state_ff       <= ST_EMIT_MOUSE;
               end
            end
            ST_EMIT_MOUSE: begin
               if (out_free) begin
                  rsp_kind_ff    <= rfdke_pkg::KIND_MOUSE;
                  rsp_word_a_ff  <= {frame_ff[7], frame_ff[6]};
                  rsp_word_b_ff  <= {frame_ff[9], frame_ff[8]};
                  rsp_word_c_ff  <= keys;
                  rsp_word_d_ff  <= keys_ctrl;
                  rsp_word_e_ff  <= keys_shift;
                  rsp_small_f_ff <= frame_ff[12];
                  rsp_small_g_ff <= frame_ff[13];
                  rsp_last_ff    <= 1'b0;
                  key_ff         <= '0;
                  state_ff       <= ST_KEY_READ;
               end
            end
            ST_KEY_READ: begin
               state_ff <= ST_KEY_UPDATE;
            end
            ST_KEY_UPDATE: begin
               if (out_free) begin
                  cnt_valid_ff[key_ff] <= 1'b1;
                  rsp_kind_ff    <= rfdke_pkg::KIND_COUNT;
                  rsp_word_a_ff  <= cnt_wide[0][15:0];
                  rsp_word_b_ff  <= cnt_wide[1][15:0];
                  rsp_word_c_ff  <= cnt_wide[2][15:0];
                  rsp_word_d_ff  <= 16'd0;
                  rsp_word_e_ff  <= 16'd0;
                  rsp_small_f_ff <= 8'(key_ff);
                  rsp_small_g_ff <= 8'd0;
                  rsp_last_ff    <= last_key;
                  if (last_key) begin
                     // Previous keys move on only once every key has been compared.
                     prev_keys_ff <= keys;
                     state_ff     <= ST_IDLE;
                  end else begin
                     key_ff   <= key_ff + 1'b1;
                     state_ff <= ST_KEY_READ;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.kind    = rsp_kind_ff;
   assign rsp_ch.word_a  = rsp_word_a_ff;
   assign rsp_ch.word_b  = rsp_word_b_ff;
   assign rsp_ch.word_c  = rsp_word_c_ff;
   assign rsp_ch.word_d  = rsp_word_d_ff;
   assign rsp_ch.word_e  = rsp_word_e_ff;
   assign rsp_ch.small_f = rsp_small_f_ff;
   assign rsp_ch.small_g = rsp_small_g_ff;
   assign rsp_ch.last    = rsp_last_ff;

   // The final item of a frame is always a count item.
   `RFDKE_ASSERT_IMP(a_last_is_count, clock, reset, rsp_valid_ff && rsp_last_ff, rsp_kind_ff == rfdke_pkg::KIND_COUNT)
   // A clear transfer leaves every counter row reading as zero.
   `RFDKE_ASSERT_NXT(a_clear_counts, clock, reset, req_accept && (req_ch.op == rfdke_pkg::OP_CLEAR), (cnt_valid_ff == '0) && (prev_keys_ff == 16'd0))
   // The byte position never runs past the frame.
   `RFDKE_ASSERT_IMP(a_pos_range, clock, reset, 1'b1, pos_ff < rfdke_pkg::POS_W'(rfdke_pkg::FRAME_BYTES))
   // Count items carry a key index that exists.
   `RFDKE_ASSERT_IMP(a_key_index, clock, reset, rsp_valid_ff && (rsp_kind_ff == rfdke_pkg::KIND_COUNT), rsp_small_f_ff < 8'(NUM_KEYS))

endmodule
